FILE: hdl/sm4_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sm4_pkg;

  localparam int ROUND_COUNT_DEF = 32;
  localparam int WORD_W = 32;
  localparam int KEY_WORDS = 4;
  localparam int CFG_IDX_W = 2;

  localparam logic KIND_ENCRYPT = 1'b0;
  localparam logic KIND_DECRYPT = 1'b1;

  localparam logic [WORD_W-1:0] FK0 = 32'hA3B1BAC6;
  localparam logic [WORD_W-1:0] FK1 = 32'h56AA3350;
  localparam logic [WORD_W-1:0] FK2 = 32'h677D9197;
  localparam logic [WORD_W-1:0] FK3 = 32'hB27022DC;

  typedef logic [7:0] sbox_tab_t [256];

  localparam sbox_tab_t SBOX = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  typedef struct packed {
    logic [WORD_W-1:0] w0;
    logic [WORD_W-1:0] w1;
    logic [WORD_W-1:0] w2;
    logic [WORD_W-1:0] w3;
  } block_t;

  function automatic logic [WORD_W-1:0] tau(input logic [WORD_W-1:0] v);
    return {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
  endfunction

  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v, input int n);
    return (v << n) | (v >> (WORD_W - n));
  endfunction

  function automatic logic [WORD_W-1:0] t_data(input logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] s;
    s = tau(v);
    return s ^ rotl(s, 2) ^ rotl(s, 10) ^ rotl(s, 18) ^ rotl(s, 24);
  endfunction

  function automatic logic [WORD_W-1:0] t_key(input logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] s;
    s = tau(v);
    return s ^ rotl(s, 13) ^ rotl(s, 23);
  endfunction

  // CK byte j of round i is (4*i + j) * 7 modulo 256.
  function automatic logic [WORD_W-1:0] ck_const(input int i);
    logic [WORD_W-1:0] r;
    r = '0;
    for (int j = 0; j < 4; j++) begin
      r = {r[23:0], 8'(((4 * i + j) * 7) % 256)};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/sm4_round_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module sm4_round_cell
  import sm4_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              vld_in,
  input  wire logic              kind_in,
  input  wire block_t            blk_in,
  input  wire logic [WORD_W-1:0] rk_enc,
  input  wire logic [WORD_W-1:0] rk_dec,
  output logic                   vld_out,
  output logic                   kind_out,
  output block_t                 blk_out
);

  logic              vld_r;
  logic              kind_r;
  block_t            blk_r;
  block_t            blk_nxt;
  logic [WORD_W-1:0] rk;

  always_comb begin
    rk = (kind_in == KIND_DECRYPT) ? rk_dec : rk_enc;
    blk_nxt.w0 = blk_in.w1;
    blk_nxt.w1 = blk_in.w2;
    blk_nxt.w2 = blk_in.w3;
    blk_nxt.w3 = blk_in.w0 ^ t_data(blk_in.w1 ^ blk_in.w2 ^ blk_in.w3 ^ rk);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kind_r <= kind_in;
      blk_r  <= blk_nxt;
    end
  end

  assign vld_out  = vld_r;
  assign kind_out = kind_r;
  assign blk_out  = blk_r;

endmodule
`default_nettype wire

FILE: hdl/sm4_key_sched.sv
`timescale 1ns / 1ps
`default_nettype none
module sm4_key_sched
  import sm4_pkg::*;
#(
  parameter int ROUND_COUNT = ROUND_COUNT_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              wr_en,
  input  wire logic [CFG_IDX_W-1:0] wr_idx,
  input  wire logic [WORD_W-1:0] wr_data,
  output logic [WORD_W-1:0]      rk [ROUND_COUNT]
);

  // The key schedule is a chain too: each stage registers one round key.
  logic [WORD_W-1:0] key_r [KEY_WORDS];
  logic [WORD_W-1:0] k_r   [ROUND_COUNT];
  logic [WORD_W-1:0] win   [ROUND_COUNT + 3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < KEY_WORDS; i++) key_r[i] <= '0;
    end else if (wr_en) begin
      key_r[wr_idx] <= wr_data;
    end
  end

  assign win[0] = key_r[0] ^ FK0;
  assign win[1] = key_r[1] ^ FK1;
  assign win[2] = key_r[2] ^ FK2;
  assign win[3] = key_r[3] ^ FK3;

  genvar g;
  generate
    for (g = 0; g < ROUND_COUNT; g++) begin : g_stage
      if (g > 0) begin : g_win
        assign win[g + 3] = k_r[g - 1];
      end
      always_ff @(posedge clk) begin
        k_r[g] <= win[g] ^ t_key(win[g + 1] ^ win[g + 2] ^ win[g + 3] ^ ck_const(g));
      end
      assign rk[g] = k_r[g];
    end
  endgenerate

endmodule
`default_nettype wire

FILE: hdl/sm4_block_cipher.sv
`timescale 1ns / 1ps
`default_nettype none
// The chain holds ROUND_COUNT round cells (32 by default) and one output register, the first cell
// loading at the transfer edge. Throughput: one block per cycle; the chain advances whenever
// the output register is free or being drained, or its last cell is empty. in_tready stays
// low after reset and after each key write while the round keys settle. Reset (rst_n low,
// synchronous) clears the key and empties the chain.
module sm4_block_cipher
  import sm4_pkg::*;
#(
  parameter int ROUND_COUNT = ROUND_COUNT_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [127:0]          in_tdata,  // data_word0, data_word1, data_word2, data_word3
  input  wire logic                  in_tuser,  // kind
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [127:0]               out_tdata, // out_word0, out_word1, out_word2, out_word3
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [WORD_W-1:0]     cfg_data
);

  localparam int SETTLE_W = $clog2(ROUND_COUNT + 1);

  logic [WORD_W-1:0] rk [ROUND_COUNT];
  logic              vld  [ROUND_COUNT + 1];
  logic              kind [ROUND_COUNT + 1];
  block_t            blk  [ROUND_COUNT + 1];
  logic              adv;
  logic              out_free;
  logic              keys_ready;
  logic [SETTLE_W-1:0] settle_r;
  logic              out_vld_r;
  logic [127:0]      out_data_r;

  assign cfg_ready = 1'b1;

  sm4_key_sched #(.ROUND_COUNT(ROUND_COUNT)) u_keys (
    .clk(clk), .rst_n(rst_n), .wr_en(cfg_valid), .wr_idx(cfg_index),
    .wr_data(cfg_data), .rk(rk)
  );

  // The settle counter holds inputs off until the last key stage is valid after the key registers change.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r <= SETTLE_W'(ROUND_COUNT);
    end else if (cfg_valid && cfg_ready) begin
      settle_r <= SETTLE_W'(ROUND_COUNT);
    end else if (settle_r != '0) begin
      settle_r <= settle_r - 1'b1;
    end
  end

  assign keys_ready = (settle_r == '0);

  // The chain stalls only when a valid result sits in its last cell and cannot move on.
  assign out_free  = !out_vld_r || out_tready;
  assign adv       = out_free || !vld[ROUND_COUNT];
  assign in_tready = adv && keys_ready;

  assign vld[0]     = in_tvalid && keys_ready;
  assign kind[0]    = in_tuser;
  assign blk[0].w0  = in_tdata[31:0];
  assign blk[0].w1  = in_tdata[63:32];
  assign blk[0].w2  = in_tdata[95:64];
  assign blk[0].w3  = in_tdata[127:96];

  genvar g;
  generate
    for (g = 0; g < ROUND_COUNT; g++) begin : g_round
      sm4_round_cell u_cell (
        .clk(clk), .rst_n(rst_n), .en(adv),
        .vld_in(vld[g]), .kind_in(kind[g]), .blk_in(blk[g]),
        .rk_enc(rk[g]), .rk_dec(rk[ROUND_COUNT - 1 - g]),
        .vld_out(vld[g + 1]), .kind_out(kind[g + 1]), .blk_out(blk[g + 1])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= vld[ROUND_COUNT];
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && vld[ROUND_COUNT]) begin
      out_data_r <= {blk[ROUND_COUNT].w0, blk[ROUND_COUNT].w1,
                     blk[ROUND_COUNT].w2, blk[ROUND_COUNT].w3};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready && vld[ROUND_COUNT] |-> !in_tready)
    else $error("chain advanced while the result was blocked");
  a_out_kept: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped before transfer");
  a_adv_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid && keys_ready |-> in_tready)
    else $error("input stalled with an empty output register");

endmodule
`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import sm4_pkg::*;

  localparam int ROUNDS = ROUND_COUNT_DEF;
  localparam int SETTLE_CYCLES = ROUNDS + 8;
  localparam int IDLE_LIMIT = 4000;
  localparam int RANDOM_BLOCKS = 1800;

  // Scoreboard that tracks the cipher key and predicts each result block.
  class sm4_scoreboard;
    logic [WORD_W-1:0] key_words [KEY_WORDS];
    logic [WORD_W-1:0] round_keys [ROUNDS];
    block_t expected_blocks [$];
    int errors;

    function new();
      foreach (key_words[i]) key_words[i] = '0;
      errors = 0;
      expand_schedule();
    endfunction

    function logic [WORD_W-1:0] sub_word(logic [WORD_W-1:0] w);
      return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    function logic [WORD_W-1:0] rot(logic [WORD_W-1:0] w, int n);
      return (w << n) | (w >> (WORD_W - n));
    endfunction

    function void expand_schedule();
      logic [WORD_W-1:0] k [4];
      logic [WORD_W-1:0] ck, s, nxt;
      k[0] = key_words[0] ^ FK0;
      k[1] = key_words[1] ^ FK1;
      k[2] = key_words[2] ^ FK2;
      k[3] = key_words[3] ^ FK3;
      for (int i = 0; i < ROUNDS; i++) begin
        ck = '0;
        for (int j = 0; j < 4; j++) ck = {ck[23:0], 8'((4 * i + j) * 7)};
        s = sub_word(k[1] ^ k[2] ^ k[3] ^ ck);
        nxt = k[0] ^ s ^ rot(s, 13) ^ rot(s, 23);
        k[0] = k[1]; k[1] = k[2]; k[2] = k[3]; k[3] = nxt;
        round_keys[i] = nxt;
      end
    endfunction

    function void set_key_word(int idx, logic [WORD_W-1:0] value);
      key_words[idx] = value;
      expand_schedule();
    endfunction

    function void note_block(logic kind, block_t blk);
      logic [WORD_W-1:0] x [4];
      logic [WORD_W-1:0] s, rk, nxt;
      block_t res;
      x[0] = blk.w0; x[1] = blk.w1; x[2] = blk.w2; x[3] = blk.w3;
      for (int i = 0; i < ROUNDS; i++) begin
        rk = (kind == KIND_DECRYPT) ? round_keys[ROUNDS - 1 - i] : round_keys[i];
        s = sub_word(x[1] ^ x[2] ^ x[3] ^ rk);
        nxt = x[0] ^ s ^ rot(s, 2) ^ rot(s, 10) ^ rot(s, 18) ^ rot(s, 24);
        x[0] = x[1]; x[1] = x[2]; x[2] = x[3]; x[3] = nxt;
      end
      res.w0 = x[3]; res.w1 = x[2]; res.w2 = x[1]; res.w3 = x[0];
      expected_blocks.push_back(res);
    endfunction

    function void check_block(block_t got);
      block_t want;
      if (expected_blocks.size() == 0) begin
        $error("result block 0x%h arrived with no block outstanding", got);
        errors++;
        return;
      end
      want = expected_blocks.pop_front();
      if (got.w0 !== want.w0) begin
        $error("out_word0 expected 0x%h actual 0x%h", want.w0, got.w0);
        errors++;
      end
      if (got.w1 !== want.w1) begin
        $error("out_word1 expected 0x%h actual 0x%h", want.w1, got.w1);
        errors++;
      end
      if (got.w2 !== want.w2) begin
        $error("out_word2 expected 0x%h actual 0x%h", want.w2, got.w2);
        errors++;
      end
      if (got.w3 !== want.w3) begin
        $error("out_word3 expected 0x%h actual 0x%h", want.w3, got.w3);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [127:0] in_tdata = '0;
  logic in_tuser = KIND_ENCRYPT;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [127:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [WORD_W-1:0] cfg_data = '0;

  sm4_scoreboard cipher_sb = new();
  int idle_cycles = 0;
  int stall_mode = 0;
  int stall_count = 0;

  sm4_block_cipher dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result words travel with word0 in the lowest bits of tdata.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      block_t got;
      got.w0 = out_tdata[31:0];
      got.w1 = out_tdata[63:32];
      got.w2 = out_tdata[95:64];
      got.w3 = out_tdata[127:96];
      cipher_sb.check_block(got);
    end
  end

  // The receiver switches between always ready, random stalls and a slow drain.
  always @(negedge clk) begin
    if (stall_count == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_count = $urandom_range(10, 120);
    end
    stall_count--;
    case (stall_mode)
      0: begin
        out_tready <= 1'b1;
      end
      1: begin
        out_tready <= 1'($urandom_range(0, 1));
      end
      default: begin
        out_tready <= (stall_count % 4 == 0);
      end
    endcase
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("sm4_block_cipher test failed");
      $finish;
    end
  end

  task automatic send_block(logic kind, block_t blk);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= {blk.w3, blk.w2, blk.w1, blk.w0};
    do @(posedge clk); while (!in_tready);
    cipher_sb.note_block(kind, blk);
  endtask

  task automatic sender_gap(int cycles);
    @(negedge clk);
    in_tvalid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic drain_results();
    sender_gap(0);
    while (cipher_sb.expected_blocks.size() != 0) @(posedge clk);
  endtask

  task automatic write_key_word(int idx, logic [WORD_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_IDX_W'(idx);
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cipher_sb.set_key_word(idx, value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Keys are only changed with the pipeline empty; the new schedule then needs time to settle.
  task automatic load_key(logic [127:0] key);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    for (int i = 0; i < KEY_WORDS; i++) write_key_word(i, key[127 - 32 * i -: 32]);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic block_t random_block();
    block_t blk;
    blk = {$urandom, $urandom, $urandom, $urandom};
    case ($urandom_range(0, 15))
      0: blk = '0;
      1: blk = '1;
      2: blk.w0 = $urandom_range(0, 1) ? '0 : '1;
      3: blk.w3 = $urandom_range(0, 1) ? '0 : '1;
      default: ;
    endcase
    return blk;
  endfunction

  task automatic random_phase(int count);
    int burst;
    burst = 0;
    for (int n = 0; n < count; n++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 40);
        if ($urandom_range(0, 2) != 0) sender_gap($urandom_range(1, 15));
      end
      burst--;
      send_block($urandom_range(0, 1) ? KIND_DECRYPT : KIND_ENCRYPT, random_block());
      if (n == count / 2) drain_results();
    end
  endtask

  initial begin
    block_t vec;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (SETTLE_CYCLES) @(posedge clk);

    // All-zero key after reset, with the extreme blocks in both directions.
    send_block(KIND_ENCRYPT, '0);
    send_block(KIND_ENCRYPT, '1);
    send_block(KIND_DECRYPT, '0);
    send_block(KIND_DECRYPT, '1);
    send_block(KIND_ENCRYPT, {32'h80000000, 32'h0, 32'h0, 32'h1});

    // Standard vector: key and plaintext both 0123456789abcdeffedcba9876543210.
    load_key(128'h0123456789abcdeffedcba9876543210);
    vec = {32'h01234567, 32'h89abcdef, 32'hfedcba98, 32'h76543210};
    send_block(KIND_ENCRYPT, vec);
    send_block(KIND_DECRYPT, {32'h681edf34, 32'hd206965e, 32'h86b3e94f, 32'h536e4246});
    send_block(KIND_DECRYPT, vec);

    // A single-word update keeps the other three key words.
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_key_word(1, 32'hffffffff);
    repeat (SETTLE_CYCLES) @(posedge clk);
    send_block(KIND_ENCRYPT, vec);
    send_block(KIND_DECRYPT, vec);

    load_key('1);
    send_block(KIND_ENCRYPT, '0);
    send_block(KIND_DECRYPT, '1);
    random_phase(RANDOM_BLOCKS / 4);

    load_key('0);
    random_phase(RANDOM_BLOCKS / 4);

    load_key({$urandom, $urandom, $urandom, $urandom});
    random_phase(RANDOM_BLOCKS / 4);

    load_key({$urandom, $urandom, $urandom, $urandom});
    random_phase(RANDOM_BLOCKS / 4);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (cipher_sb.errors == 0 && cipher_sb.expected_blocks.size() == 0) begin
      $display("sm4_block_cipher test passed");
    end else begin
      $display("sm4_block_cipher test failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/sm4_pkg.sv
hdl/sm4_round_cell.sv
hdl/sm4_key_sched.sv
hdl/sm4_block_cipher.sv
tb/tb_top.sv
